// ----- hw/rtl/tvm_pkg.sv -----
// shared types and constants for the time value of money unit
package tvm_pkg;

	localparam logic [2:0] OP_FV   = 3'd0;
	localparam logic [2:0] OP_PV   = 3'd1;
	localparam logic [2:0] OP_APV  = 3'd2;
	localparam logic [2:0] OP_AFV  = 3'd3;
	localparam logic [2:0] OP_BOND = 3'd4;

	localparam logic [62:0] VAL_MAX = {63{1'b1}};
	localparam logic [33:0] DUR_MAX = {34{1'b1}};
	localparam logic [63:0] ONE_Q32 = 64'h1_0000_0000;

	typedef struct packed {
		logic [2:0]  req_type;
		logic [39:0] amount;
		logic [23:0] rate;
		logic [23:0] coupon_rate;
		logic [9:0]  periods;
	} req_t;

	typedef struct packed {
		logic [62:0] value;
		logic [33:0] duration;
		logic        overflow;
	} rsp_t;

	// multiply request: floor(a*b / 2^shift)
	typedef struct packed {
		logic [63:0] a;
		logic [63:0] b;
		logic [5:0]  shift;
	} mul_req_t;

	typedef struct packed {
		logic [63:0] res;
		logic        sat;
	} mul_rsp_t;

endpackage

// ----- hw/rtl/tvm_mul.sv -----
// 64x64 multiplier built from one 32x32 product per cycle, with shift and saturation
module tvm_mul (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  tvm_pkg::mul_req_t req,
	output logic              done,
	output tvm_pkg::mul_rsp_t rsp
);
	import tvm_pkg::*;

	logic [63:0]  a_q, b_q;
	logic [5:0]   s_q;
	logic [127:0] acc_q;
	logic [1:0]   cnt_q;
	logic         busy_q;
	logic         done_q;
	logic [31:0]  a_half, b_half;
	logic [63:0]  pp;
	logic [127:0] pp_sh;
	logic [127:0] acc_sh;

	assign a_half = cnt_q[1] ? a_q[63:32] : a_q[31:0];
	assign b_half = cnt_q[0] ? b_q[63:32] : b_q[31:0];
	assign pp     = 64'(a_half) * 64'(b_half);

	always_comb begin
		case ({1'b0, cnt_q[1]} + {1'b0, cnt_q[0]})
			2'd0:    pp_sh = {64'd0, pp};
			2'd1:    pp_sh = {32'd0, pp, 32'd0};
			default: pp_sh = {pp, 64'd0};
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 2'd1;
				if (cnt_q == 2'd3) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q   <= req.a;
			b_q   <= req.b;
			s_q   <= req.shift;
			acc_q <= '0;
		end else if (busy_q) begin
			acc_q <= acc_q + pp_sh;
		end
	end

	assign acc_sh  = acc_q >> s_q;
	assign done    = done_q;
	assign rsp.sat = (acc_sh[127:64] != 64'd0);
	assign rsp.res = rsp.sat ? {64{1'b1}} : acc_sh[63:0];

endmodule

// ----- hw/rtl/tvm_div.sv -----
// restoring divider, one quotient bit per cycle, dividend fed msb first
module tvm_div (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [87:0] num,
	input  logic [6:0]  steps,
	input  logic [63:0] den,
	output logic        done,
	output logic [63:0] quo,
	output logic        quo_ovf,
	output logic [63:0] rem
);
	import tvm_pkg::*;

	logic [87:0] num_q;
	logic [63:0] den_q;
	logic [63:0] rem_q;
	logic [63:0] quo_q;
	logic        ovf_q;
	logic [6:0]  cnt_q;
	logic        busy_q;
	logic        done_q;
	logic [64:0] trial;
	logic        qbit;

	assign trial = {rem_q, num_q[87]};
	assign qbit  = (trial >= {1'b0, den_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= steps;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 7'd1;
				if (cnt_q == 7'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= num;
			den_q <= den;
			rem_q <= '0;
			quo_q <= '0;
			ovf_q <= 1'b0;
		end else if (busy_q) begin
			num_q <= {num_q[86:0], 1'b0};
			rem_q <= qbit ? 64'(trial - {1'b0, den_q}) : trial[63:0];
			quo_q <= {quo_q[62:0], qbit};
			ovf_q <= ovf_q | quo_q[63];
		end
	end

	assign done    = done_q;
	assign quo     = quo_q;
	assign quo_ovf = ovf_q;
	assign rem     = rem_q;

endmodule

// ----- hw/rtl/time_value_of_money_unit.sv -----
// time value of money unit: sequencer around a shared multiplier and a divider
// one request at a time, next request accepted after the response; the run time
// grows with the number of periods, and a bond adds its coupon sums and duration;
// it is set mostly by the iterative multiplier, used three times per period
// reset: arst_n clears the sequencer and output valid; no request in flight after reset
module time_value_of_money_unit #(
	parameter int MAX_PERIODS    = 1023,
	parameter int RATE_FRAC_BITS = 24
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_stall,
	input  tvm_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_stall,
	output tvm_pkg::rsp_t rsp
);
	import tvm_pkg::*;

	// period counter holds up to MAX_PERIODS + 1
	localparam int KW = $clog2(MAX_PERIODS + 2);
	localparam int RSH = 32 - RATE_FRAC_BITS;
	localparam logic [31:0] RMASK = (RATE_FRAC_BITS >= 32) ? 32'hFFFF_FFFF
		: 32'((64'd1 << RATE_FRAC_BITS) - 64'd1);
	localparam logic [16:0] MAXP = 17'(MAX_PERIODS);

	typedef enum logic [3:0] {
		S_IDLE, S_RECIP, S_LOOP, S_GROW, S_DISC, S_TSUM,
		S_PCPN, S_WCPN, S_WEND, S_VAL, S_DUR, S_FIN, S_OUT
	} state_t;

	state_t      state_q;
	logic        wait_q;
	logic [2:0]  op_q;
	logic [39:0] amt_q;
	logic [31:0] cq_q;
	logic [32:0] base_q;
	logic [KW-1:0] n_q, k_q;
	logic [63:0] d1_q, g_q, d_q, sd_q, sg_q, t_q, pf_q, wf_q, v_q;
	logic        gsat_q, vsat_q;
	logic [33:0] dur_q;
	rsp_t        rsp_q;
	logic        rsp_valid_q;

	logic        mul_start, mul_done;
	mul_req_t    mreq;
	mul_rsp_t    mrsp;
	logic        div_start, div_done, div_ovf;
	logic [87:0] div_num;
	logic [6:0]  div_steps;
	logic [63:0] div_den, div_quo, div_rem;

	logic [31:0] rq_in, cq_in;
	logic [64:0] sg_sum;
	logic [64:0] rem_inc;
	logic [63:0] val_sel;
	logic        is_mul_state;

	tvm_mul u_mul (
		.clk(clk), .arst_n(arst_n), .start(mul_start),
		.req(mreq), .done(mul_done), .rsp(mrsp)
	);

	tvm_div u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start),
		.num(div_num), .steps(div_steps), .den(div_den),
		.done(div_done), .quo(div_quo), .quo_ovf(div_ovf), .rem(div_rem)
	);

	// rates widened to q0.32, bits above the fraction dropped
	assign rq_in = (32'(req.rate) & RMASK) << RSH;
	assign cq_in = (32'(req.coupon_rate) & RMASK) << RSH;

	assign sg_sum  = {1'b0, sg_q} + {1'b0, g_q};
	assign rem_inc = {1'b0, div_rem} + 65'd1;

	always_comb begin
		case (op_q)
			OP_FV:   val_sel = g_q;
			OP_PV:   val_sel = d_q;
			OP_APV:  val_sel = sd_q;
			OP_AFV:  val_sel = sg_q;
			default: val_sel = pf_q;
		endcase
	end

	// operand select for the shared multiplier
	always_comb begin
		mreq = '0;
		is_mul_state = 1'b1;
		case (state_q)
			S_GROW: mreq = '{a: g_q, b: 64'(base_q), shift: 6'd32};
			S_DISC: mreq = '{a: d_q, b: d1_q, shift: 6'd32};
			S_TSUM: mreq = '{a: 64'(k_q), b: d_q, shift: 6'd0};
			S_PCPN: mreq = '{a: 64'(cq_q), b: sd_q, shift: 6'd32};
			S_WCPN: mreq = '{a: 64'(cq_q), b: t_q, shift: 6'd32};
			S_WEND: mreq = '{a: 64'(n_q), b: d_q, shift: 6'd0};
			S_VAL:  mreq = '{a: 64'(amt_q), b: val_sel, shift: 6'd16};
			default: is_mul_state = 1'b0;
		endcase
	end

	assign mul_start = is_mul_state && !wait_q;
	assign div_start = (state_q == S_RECIP || state_q == S_DUR) && !wait_q;
	// reciprocal uses the top 64 bits (all ones) for 2^64-1 over the base
	assign div_num   = (state_q == S_RECIP) ? {{64{1'b1}}, 24'd0} : {wf_q, 24'd0};
	assign div_steps = (state_q == S_RECIP) ? 7'd64 : 7'd88;
	assign div_den   = (state_q == S_RECIP) ? 64'(base_q) : pf_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			wait_q      <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (req_valid) begin
						state_q <= (req.req_type > OP_BOND) ? S_FIN : S_RECIP;
					end
				end
				S_RECIP, S_DUR: begin
					if (!wait_q) begin
						wait_q <= 1'b1;
					end else if (div_done) begin
						wait_q  <= 1'b0;
						state_q <= (state_q == S_RECIP) ? S_LOOP : S_FIN;
					end
				end
				S_LOOP: begin
					if (k_q > n_q) begin
						state_q <= (op_q == OP_BOND) ? S_PCPN : S_VAL;
					end else begin
						state_q <= S_GROW;
					end
				end
				S_GROW, S_DISC, S_TSUM, S_PCPN, S_WCPN, S_WEND, S_VAL: begin
					if (!wait_q) begin
						wait_q <= 1'b1;
					end else if (mul_done) begin
						wait_q <= 1'b0;
						case (state_q)
							S_GROW:  state_q <= S_DISC;
							S_DISC:  state_q <= S_TSUM;
							S_TSUM:  state_q <= S_LOOP;
							S_PCPN:  state_q <= S_WCPN;
							S_WCPN:  state_q <= S_WEND;
							S_WEND:  state_q <= S_VAL;
							default: begin
								// duration only for a bond whose price and amount are nonzero
								if (op_q == OP_BOND && amt_q != 40'd0 && pf_q != 64'd0) begin
									state_q <= S_DUR;
								end else begin
									state_q <= S_FIN;
								end
							end
						endcase
					end
				end
				S_FIN: begin
					rsp_valid_q <= 1'b1;
					state_q     <= S_OUT;
				end
				S_OUT: begin
					if (!rsp_stall) begin
						rsp_valid_q <= 1'b0;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				op_q   <= req.req_type;
				amt_q  <= req.amount;
				cq_q   <= cq_in;
				base_q <= {1'b1, rq_in};
				// periods above the limit clamp to it
				n_q    <= (17'(req.periods) > MAXP) ? KW'(MAXP) : KW'(req.periods);
				v_q    <= '0;
				vsat_q <= 1'b0;
				dur_q  <= '0;
			end
			S_RECIP: begin
				if (div_done) begin
					// round to nearest: 2^64 = q*base + rem + 1
					d1_q   <= ({rem_inc[63:0], 1'b0} >= {32'd0, base_q}) ? div_quo + 64'd1
						: div_quo;
					g_q    <= ONE_Q32;
					d_q    <= ONE_Q32;
					sd_q   <= '0;
					sg_q   <= '0;
					t_q    <= '0;
					gsat_q <= 1'b0;
					k_q    <= KW'(1);
				end
			end
			S_LOOP: begin
				if (k_q <= n_q) begin
					if (sg_sum[64]) begin
						sg_q   <= {64{1'b1}};
						gsat_q <= 1'b1;
					end else begin
						sg_q <= sg_sum[63:0];
					end
				end
			end
			S_GROW: begin
				if (mul_done) begin
					g_q    <= mrsp.res;
					gsat_q <= gsat_q | mrsp.sat;
				end
			end
			S_DISC: begin
				if (mul_done) begin
					d_q  <= mrsp.res;
					sd_q <= sd_q + mrsp.res;
				end
			end
			S_TSUM: begin
				if (mul_done) begin
					t_q <= t_q + mrsp.res;
					k_q <= k_q + KW'(1);
				end
			end
			S_PCPN: begin
				if (mul_done) pf_q <= mrsp.res + d_q;
			end
			S_WCPN: begin
				if (mul_done) wf_q <= mrsp.res;
			end
			S_WEND: begin
				if (mul_done) wf_q <= wf_q + mrsp.res;
			end
			S_VAL: begin
				if (mul_done) begin
					v_q    <= mrsp.res;
					vsat_q <= mrsp.sat | (gsat_q & (op_q == OP_FV || op_q == OP_AFV));
				end
			end
			S_DUR: begin
				if (div_done) begin
					dur_q <= (div_ovf || div_quo[63:34] != 30'd0) ? DUR_MAX : div_quo[33:0];
				end
			end
			S_FIN: begin
				if (amt_q == 40'd0) begin
					rsp_q.value    <= '0;
					rsp_q.overflow <= 1'b0;
				end else if (vsat_q || v_q[63]) begin
					rsp_q.value    <= VAL_MAX;
					rsp_q.overflow <= 1'b1;
				end else begin
					rsp_q.value    <= v_q[62:0];
					rsp_q.overflow <= 1'b0;
				end
				rsp_q.duration <= dur_q;
			end
			default: ;
		endcase
	end

	assign req_stall = (state_q != S_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule
